FILE: sv/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants of the variable-width LZW decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int DictEntries = 4096;
  localparam int AddrW       = $clog2(DictEntries);
  localparam int CntW        = AddrW + 1;
  localparam int LenW        = 25;
  localparam int MaxCodeW    = 12;
  localparam int StartCodeW  = 9;

  localparam logic [AddrW-1:0] ClearCode = AddrW'(256);
  localparam logic [CntW-1:0]  FirstFree = CntW'(257);
  localparam logic [CntW-1:0]  ClearFree = CntW'(256);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FEED,
    S_FEED_END,
    S_LAST_CHK,
    S_TAKE,
    S_WALK,
    S_WALK_WAIT,
    S_DRAIN,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    RET_FEED,
    RET_LAST,
    RET_DRAIN
  } ret_e;

  typedef enum logic [2:0] {
    ST_BYTE    = 3'd0,
    ST_BUSY    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_INVALID = 3'd3,
    ST_LENGTH  = 3'd4
  } status_e;

  typedef enum logic {
    OP_FEED  = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [AddrW-1:0] prefix;
    logic [7:0]       suffix;
    logic             re;
    logic [AddrW-1:0] raddr;
  } dict_req_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } stack_req_t;

endpackage

FILE: sv/lzw_variable_width_decoder.sv
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder
// LZW decoder, 9 to 12 bit codes taken LSB first, drained one byte per beat.
// ----------------------------------------------------------------------------
// One beat is handled at a time; s_axis_tready is high only while idle.
// A feed beat (tuser 0) holds the input while the bit gatherer takes its
// compressed bits one at a time after the accept cycle, then passes an exit
// state and a wrap-up state; a final beat adds a length check. A code
// completed in that byte adds a read and a push per dictionary entry walked
// (registered dictionary read, then stack push) plus a take step and a
// final push (the take step alone for a clear or the first code). A drain
// beat (tuser 1) passes the registered stack read, more if it finishes a
// pending tail code. Each answer then waits in the output register until
// taken. Code 256 clears the table and skips to the end of the current
// 8-code block; a feed while decoded bytes remain is answered busy. The
// dictionary and stack hold garbage after reset and need no clearing.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [24:0] cfg_wdata_i,     // expected_length
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] in_byte
  input  logic        s_axis_tuser_i,  // [0] op
  input  logic        s_axis_tlast_i,  // in_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] out_byte
  output logic [2:0]  m_axis_tuser_o,  // [2:0] status
  output logic        m_axis_tlast_o   // out_last
);
  import lzwd_pkg::*;

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;

  logic [LenW-1:0]     exp_q;
  logic [CntW-1:0]     count_q, count_d;
  logic [AddrW-1:0]    acc_q, acc_d;
  logic [3:0]          held_q, held_d;
  logic [3:0]          width_q, width_d;
  logic [CntW-1:0]     nf_q, nf_d;
  logic [6:0]          pos_q, pos_d;    // block bit position modulo 8 codes
  logic [6:0]          skip_q, skip_d;
  logic [AddrW-1:0]    prev_q, prev_d;
  logic [8:0]          pfb_q, pfb_d;
  logic [LenW-1:0]     emit_q, emit_d;
  logic                first_q, first_d;
  logic                failed_q, failed_d;
  logic                ended_q, ended_d;
  logic                tail_q, tail_d;

  // per-beat work registers
  logic [7:0]          byte_q, byte_d;
  logic                last_q, last_d;
  logic [3:0]          bcnt_q, bcnt_d;
  logic [AddrW-1:0]    c_q, c_d;        // code being taken
  logic [AddrW-1:0]    code_q, code_d;  // walk pointer
  logic [CntW-1:0]     n_q, n_d;        // bytes pushed this code

  logic [7:0]          res_byte_q, res_byte_d;
  logic                res_last_q, res_last_d;
  status_e             res_st_q, res_st_d;

  logic                m_valid_q, m_valid_d;
  logic [7:0]          m_data_q, m_data_d;
  logic [2:0]          m_user_q, m_user_d;
  logic                m_last_q, m_last_d;

  dict_req_t           dict_req;
  stack_req_t          stack_req;
  logic [AddrW-1:0]    dict_prefix;
  logic [7:0]          dict_suffix;
  logic [7:0]          stack_rdata;

  logic                s_fire;
  logic                take_done;
  logic                bit_v;
  logic                skipping;
  logic                code_done;
  logic [AddrW-1:0]    acc_new;
  logic [7:0]          pos_sum;
  logic [6:0]          block_len;
  logic [6:0]          pos_new;
  logic                len_reached;

  lzwd_dict u_dict (
    .clk_i    (clk_i),
    .req_i    (dict_req),
    .prefix_o (dict_prefix),
    .suffix_o (dict_suffix)
  );

  lzwd_stack u_stack (
    .clk_i   (clk_i),
    .req_i   (stack_req),
    .rdata_o (stack_rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign skipping  = (skip_q != 7'd0);
  assign bit_v     = byte_q[bcnt_q[2:0]];
  assign acc_new   = acc_q | (AddrW'(bit_v) << held_q);
  assign code_done = !skipping && ((held_q + 4'd1) == width_q);

  // running position modulo one block of eight codes
  assign block_len = {width_q, 3'b000};
  assign pos_sum   = {1'b0, pos_q} + {4'b0000, width_q};
  assign pos_new   = (pos_sum >= {1'b0, block_len}) ? 7'(pos_sum - {1'b0, block_len})
                                                    : pos_sum[6:0];
  assign len_reached = (emit_q >= exp_q);

  // datapath
  always_comb begin
    ret_d      = ret_q;
    count_d    = count_q;
    acc_d      = acc_q;
    held_d     = held_q;
    width_d    = width_q;
    nf_d       = nf_q;
    pos_d      = pos_q;
    skip_d     = skip_q;
    prev_d     = prev_q;
    pfb_d      = pfb_q;
    emit_d     = emit_q;
    first_d    = first_q;
    failed_d   = failed_q;
    ended_d    = ended_q;
    tail_d     = tail_q;
    byte_d     = byte_q;
    last_d     = last_q;
    bcnt_d     = bcnt_q;
    c_d        = c_q;
    code_d     = code_q;
    n_d        = n_q;
    res_byte_d = res_byte_q;
    res_last_d = res_last_q;
    res_st_d   = res_st_q;
    dict_req   = '0;
    stack_req  = '0;
    take_done  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          byte_d     = s_axis_tdata_i;
          last_d     = s_axis_tlast_i;
          bcnt_d     = 4'd0;
          res_byte_d = 8'd0;
          res_last_d = 1'b0;
          if (exp_q == '0) begin
            res_st_d = ST_LENGTH;
          end else if (failed_q) begin
            res_st_d = ST_INVALID;
          end else if (s_axis_tuser_i == OP_FEED) begin
            res_st_d = ST_BUSY;
          end else if (count_q != '0) begin
            stack_req.re    = 1'b1;
            stack_req.raddr = AddrW'(count_q - CntW'(1));
            count_d         = count_q - CntW'(1);
            emit_d          = emit_q + LenW'(1);
          end else if (ended_q && !len_reached) begin
            res_st_d = ST_LENGTH;
          end else begin
            res_st_d = ST_EMPTY;
          end
        end
      end

      S_FEED: begin
        if (bcnt_q != 4'd8) begin
          bcnt_d = bcnt_q + 4'd1;
          if (skipping) begin
            skip_d = skip_q - 7'd1;
          end else if (code_done) begin
            c_d    = acc_new;
            acc_d  = '0;
            held_d = 4'd0;
            ret_d  = RET_FEED;
          end else begin
            acc_d  = acc_new;
            held_d = held_q + 4'd1;
          end
        end
      end

      S_FEED_END: begin
        if (last_q) begin
          ended_d = 1'b1;
          skip_d  = 7'd0;
          if (held_q != 4'd0) begin
            if (count_q == '0) begin
              c_d    = acc_q;
              acc_d  = '0;
              held_d = 4'd0;
              ret_d  = RET_LAST;
            end else begin
              tail_d = 1'b1;
            end
          end
        end
      end

      S_LAST_CHK: begin
        res_byte_d = 8'd0;
        res_last_d = 1'b0;
        res_st_d   = ST_LENGTH;
      end

      S_TAKE: begin
        if (!first_q) begin
          first_d         = 1'b1;
          stack_req.we    = 1'b1;
          stack_req.waddr = '0;
          stack_req.wdata = c_q[7:0];
          count_d         = CntW'(1);
          pfb_d           = c_q[8:0];
          prev_d          = c_q;
          take_done       = 1'b1;
        end else if (len_reached) begin
          take_done = 1'b1;
        end else if (c_q == ClearCode) begin
          skip_d    = (pos_new == 7'd0) ? 7'd0 : 7'(block_len - pos_new);
          width_d   = 4'(StartCodeW);
          nf_d      = ClearFree;
          pos_d     = 7'd0;
          take_done = 1'b1;
        end else begin
          pos_d = pos_new;
          if ({1'b0, c_q} > nf_q) begin
            failed_d  = 1'b1;
            count_d   = '0;
            tail_d    = 1'b0;
            take_done = 1'b1;
          end else if ({1'b0, c_q} == nf_q) begin
            // code not yet in the table: previous string plus its first byte
            stack_req.we    = 1'b1;
            stack_req.waddr = '0;
            stack_req.wdata = pfb_q[7:0];
            n_d             = CntW'(1);
            code_d          = prev_q;
          end else begin
            n_d    = '0;
            code_d = c_q;
          end
        end
      end

      S_WALK: begin
        if (n_q >= CntW'(DictEntries)) begin
          failed_d  = 1'b1;
          count_d   = '0;
          tail_d    = 1'b0;
          take_done = 1'b1;
        end else if (code_q[AddrW-1:8] != '0) begin
          dict_req.re    = 1'b1;
          dict_req.raddr = code_q;
        end else begin
          stack_req.we    = 1'b1;
          stack_req.waddr = n_q[AddrW-1:0];
          stack_req.wdata = code_q[7:0];
          count_d         = n_q + CntW'(1);
          pfb_d           = {1'b0, code_q[7:0]};
          if (nf_q < CntW'(DictEntries)) begin
            dict_req.we     = 1'b1;
            dict_req.waddr  = nf_q[AddrW-1:0];
            dict_req.prefix = prev_q;
            dict_req.suffix = code_q[7:0];
            nf_d            = nf_q + CntW'(1);
            if ((nf_q + CntW'(1)) >= (CntW'(1) << width_q) &&
                width_q < 4'(MaxCodeW)) begin
              width_d = width_q + 4'd1;
              pos_d   = 7'd0;
            end
          end
          prev_d    = c_q;
          take_done = 1'b1;
        end
      end

      S_WALK_WAIT: begin
        stack_req.we    = 1'b1;
        stack_req.waddr = n_q[AddrW-1:0];
        stack_req.wdata = dict_suffix;
        n_d             = n_q + CntW'(1);
        code_d          = dict_prefix;
      end

      S_DRAIN: begin
        res_byte_d = stack_rdata;
        res_st_d   = ST_BYTE;
        if (len_reached) begin
          count_d    = '0;
          tail_d     = 1'b0;
          res_last_d = 1'b1;
        end else if (count_q == '0 && tail_q) begin
          c_d    = acc_q;
          acc_d  = '0;
          held_d = 4'd0;
          tail_d = 1'b0;
          ret_d  = RET_DRAIN;
        end else begin
          res_last_d = (count_q == '0) && ended_q;
        end
      end

      S_RESP: begin
      end

      default: begin
      end
    endcase

    // answer after a code is taken
    if (take_done) begin
      res_byte_d = 8'd0;
      res_last_d = 1'b0;
      res_st_d   = ST_INVALID;
      if (ret_q == RET_DRAIN) begin
        res_byte_d = stack_rdata;
        res_last_d = (count_d == '0) && ended_q && !failed_d;
        res_st_d   = ST_BYTE;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if (exp_q == '0 || failed_q) begin
            state_d = S_RESP;
          end else if (s_axis_tuser_i == OP_FEED) begin
            if (count_q != '0) begin
              state_d = S_RESP;
            end else if (ended_q || len_reached) begin
              state_d = S_IDLE;
            end else begin
              state_d = S_FEED;
            end
          end else if (count_q != '0) begin
            state_d = S_DRAIN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_FEED: begin
        if (bcnt_q == 4'd8) begin
          state_d = S_FEED_END;
        end else if (!skipping && code_done) begin
          state_d = S_TAKE;
        end
      end
      S_FEED_END: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (held_q != 4'd0 && count_q == '0) begin
          state_d = S_TAKE;
        end else begin
          state_d = S_LAST_CHK;
        end
      end
      S_LAST_CHK: begin
        state_d = (count_q == '0 && !len_reached) ? S_RESP : S_IDLE;
      end
      S_TAKE, S_WALK: begin
        if (take_done) begin
          unique case (ret_q)
            RET_FEED:  state_d = failed_d ? S_RESP : S_FEED;
            RET_LAST:  state_d = failed_d ? S_RESP : S_LAST_CHK;
            RET_DRAIN: state_d = S_RESP;
            default:   state_d = S_RESP;
          endcase
        end else if (state_q == S_WALK) begin
          state_d = S_WALK_WAIT;
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK_WAIT: state_d = S_WALK;
      S_DRAIN: begin
        if (!len_reached && count_q == '0 && tail_q) begin
          state_d = S_TAKE;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    if (state_q == S_RESP && (!m_valid_q || m_axis_tready_i)) begin
      m_valid_d = 1'b1;
      m_data_d  = res_byte_q;
      m_user_d  = res_st_q;
      m_last_d  = res_last_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= RET_FEED;
      exp_q     <= LenW'(1);
      count_q   <= '0;
      acc_q     <= '0;
      held_q    <= 4'd0;
      width_q   <= 4'(StartCodeW);
      nf_q      <= FirstFree;
      pos_q     <= 7'd0;
      skip_q    <= 7'd0;
      prev_q    <= '0;
      pfb_q     <= 9'd0;
      emit_q    <= '0;
      first_q   <= 1'b0;
      failed_q  <= 1'b0;
      ended_q   <= 1'b0;
      tail_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      if (cfg_we_i) begin
        exp_q <= cfg_wdata_i;
      end
      count_q   <= count_d;
      acc_q     <= acc_d;
      held_q    <= held_d;
      width_q   <= width_d;
      nf_q      <= nf_d;
      pos_q     <= pos_d;
      skip_q    <= skip_d;
      prev_q    <= prev_d;
      pfb_q     <= pfb_d;
      emit_q    <= emit_d;
      first_q   <= first_d;
      failed_q  <= failed_d;
      ended_q   <= ended_d;
      tail_q    <= tail_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    last_q     <= last_d;
    bcnt_q     <= bcnt_d;
    c_q        <= c_d;
    code_q     <= code_d;
    n_q        <= n_d;
    res_byte_q <= res_byte_d;
    res_last_q <= res_last_d;
    res_st_q   <= res_st_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
    m_last_q   <= m_last_d;
  end

`ifndef NO_ASSERTIONS
  a_failed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |=> failed_q) else $error("failed flag dropped");

  a_held_below_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q < width_q) else $error("bit gatherer overran code width");

  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_q >= 4'(StartCodeW) && width_q <= 4'(MaxCodeW))
    else $error("code width out of range");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DictEntries)) else $error("stack count overflow");
`endif

endmodule

FILE: sv/lzwd_dict.sv
// ----------------------------------------------------------------------------
// lzwd_dict
// Dictionary memory: prefix and suffix per entry, one write, one read port.
// ----------------------------------------------------------------------------
module lzwd_dict (
  input  logic                    clk_i,
  input  lzwd_pkg::dict_req_t     req_i,
  output logic [lzwd_pkg::AddrW-1:0] prefix_o,
  output logic [7:0]              suffix_o
);
  import lzwd_pkg::*;

  logic [AddrW-1:0] prefix_mem [DictEntries];
  logic [7:0]       suffix_mem [DictEntries];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      prefix_mem[req_i.waddr] <= req_i.prefix;
      suffix_mem[req_i.waddr] <= req_i.suffix;
    end
    if (req_i.re) begin
      prefix_o <= prefix_mem[req_i.raddr];
      suffix_o <= suffix_mem[req_i.raddr];
    end
  end

endmodule

FILE: sv/lzwd_stack.sv
// ----------------------------------------------------------------------------
// lzwd_stack
// Expansion stack memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lzwd_stack (
  input  logic                 clk_i,
  input  lzwd_pkg::stack_req_t req_i,
  output logic [7:0]           rdata_o
);
  import lzwd_pkg::*;

  logic [7:0] mem [DictEntries];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule
